@@ src/tli_pkg.sv @@
// Package for the table linear interpolator: sizes, codes and packed item types.
// No dependencies.
`default_nettype none
package tli_pkg;
    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int VAL_W          = 32;
    localparam int DIV_W          = 33;  // width of dx and of the magnitude of dy
    localparam int PROD_W         = 66;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] CLAMP_NONE  = 2'd0;
    localparam logic [1:0] CLAMP_FIRST = 2'd1;
    localparam logic [1:0] CLAMP_LAST  = 2'd2;

    // Per-item context that follows an evaluation through the divider.
    typedef struct packed {
        logic              neg;
        logic              zero_dx;
        logic [1:0]        code;
        logic signed [31:0] base_y;
    } ctx_t;
endpackage
`default_nettype wire

@@ src/tli_divider.sv @@
// Pipelined unsigned divider, one quotient bit per stage, with stall support.
// Depends on tli_pkg for the context type carried alongside.
`default_nettype none
module tli_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic                        in_valid,
    input  wire logic [tli_pkg::PROD_W-1:0]  in_num,
    input  wire logic [tli_pkg::DIV_W-1:0]   in_den,
    input  wire tli_pkg::ctx_t               in_ctx,
    output logic                             out_valid,
    output logic [tli_pkg::PROD_W-1:0]       out_quot,
    output tli_pkg::ctx_t                    out_ctx
);
    import tli_pkg::*;
    localparam int STAGES = PROD_W;

    logic              v_reg   [STAGES+1];
    logic [PROD_W-1:0] q_reg   [STAGES+1];
    logic [DIV_W-1:0]  r_reg   [STAGES+1];
    logic [DIV_W-1:0]  d_reg   [STAGES+1];
    ctx_t              c_reg   [STAGES+1];

    always_comb begin
        v_reg[0] = in_valid;
        q_reg[0] = in_num;
        r_reg[0] = '0;
        d_reg[0] = in_den;
        c_reg[0] = in_ctx;
    end

    // Each stage shifts one numerator bit into the remainder and restores.
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        assign trial = {r_reg[s], q_reg[s][PROD_W-1]};
        assign diff  = trial - {1'b0, d_reg[s]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s+1] <= 1'b0;
            end else if (advance) begin
                v_reg[s+1] <= v_reg[s];
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) begin
                d_reg[s+1] <= d_reg[s];
                c_reg[s+1] <= c_reg[s];
                if (!diff[DIV_W]) begin
                    r_reg[s+1] <= diff[DIV_W-1:0];
                    q_reg[s+1] <= {q_reg[s][PROD_W-2:0], 1'b1};
                end else begin
                    r_reg[s+1] <= trial[DIV_W-1:0];
                    q_reg[s+1] <= {q_reg[s][PROD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_quot  = q_reg[STAGES];
    assign out_ctx   = c_reg[STAGES];
endmodule
`default_nettype wire

@@ src/tli_front.sv @@
// Breakpoint table, segment search and product stage of the interpolator.
// Depends on tli_pkg.
`default_nettype none
module tli_front #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic                       in_valid,
    input  wire logic                       in_cmd,
    input  wire logic [3:0]                 in_index,
    input  wire logic signed [31:0]         in_px,
    input  wire logic signed [31:0]         in_py,
    input  wire logic signed [31:0]         in_x,
    input  wire logic [4:0]                 count,
    output logic                            out_valid,
    output logic [tli_pkg::PROD_W-1:0]      out_num,
    output logic [tli_pkg::DIV_W-1:0]       out_den,
    output tli_pkg::ctx_t                   out_ctx
);
    import tli_pkg::*;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic signed [31:0] tx_reg [MAX_POINTS];
    logic signed [31:0] ty_reg [MAX_POINTS];

    // Table writes; slots beyond the table are dropped.
    always_ff @(posedge aclk) begin
        if (advance && in_valid && in_cmd == CMD_WRITE && 32'(in_index) < MAX_POINTS) begin
            tx_reg[IW'(in_index)] <= in_px;
            ty_reg[IW'(in_index)] <= in_py;
        end
    end

    // Stage 1: per-segment hit bits and the effective count.
    logic [MAX_POINTS-1:0] hit_next, hit_reg;
    logic                  le0_next, le0_reg;
    logic [CW-1:0]         n_next, n_reg;
    logic signed [31:0]    x1_reg;
    logic                  v1_reg;
    always_comb begin
        if (count == 5'd0) begin
            n_next = CW'(1);
        end else if (32'(count) > MAX_POINTS) begin
            n_next = CW'(MAX_POINTS);
        end else begin
            n_next = CW'(count);
        end
        hit_next = '0;
        for (int i = 1; i < MAX_POINTS; i++) begin
            hit_next[i] = (in_x >= tx_reg[i-1]) && (in_x <= tx_reg[i]) && (i < 32'(n_next));
        end
        le0_next = in_x <= tx_reg[0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid && in_cmd == CMD_EVAL;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg <= hit_next;
            le0_reg <= le0_next;
            n_reg   <= n_next;
            x1_reg  <= in_x;
        end
    end

    // Stage 2: pick the first segment and fetch its end points.
    logic [IW-1:0]      seg;
    logic               found;
    always_comb begin
        seg   = '0;
        found = 1'b0;
        for (int i = MAX_POINTS - 1; i >= 1; i--) begin
            if (hit_reg[i]) begin
                seg   = IW'(i);
                found = 1'b1;
            end
        end
    end
    logic                v2_reg, found_reg;
    logic signed [32:0]  dx_reg, dy_reg, ox_reg;
    logic signed [31:0]  y0_reg;
    logic [1:0]          code_reg;
    logic [IW-1:0]       last;
    assign last = IW'(n_reg - CW'(1));
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            found_reg <= found;
            dx_reg <= 33'(tx_reg[seg]) - 33'(tx_reg[seg - IW'(1)]);
            dy_reg <= 33'(ty_reg[seg]) - 33'(ty_reg[seg - IW'(1)]);
            ox_reg <= 33'(x1_reg) - 33'(tx_reg[seg - IW'(1)]);
            if (found) begin
                y0_reg   <= ty_reg[seg - IW'(1)];
                code_reg <= CLAMP_NONE;
            end else if (le0_reg) begin
                y0_reg   <= ty_reg[0];
                code_reg <= CLAMP_FIRST;
            end else begin
                y0_reg   <= ty_reg[last];
                code_reg <= CLAMP_LAST;
            end
        end
    end

    // Stage 3: magnitude product |dy| * (x - x0).
    logic [32:0] mag;
    assign mag = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    logic v3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_num <= found_reg ? PROD_W'(mag) * PROD_W'(ox_reg[32:0]) : '0;
            out_den <= (found_reg && dx_reg != '0) ? dx_reg[32:0] : DIV_W'(1);
            out_ctx <= '{neg: dy_reg[32], zero_dx: !found_reg || dx_reg == '0,
                         code: code_reg, base_y: y0_reg};
        end
    end
    assign out_valid = v3_reg;
endmodule
`default_nettype wire

@@ src/table_linear_interpolator_top.sv @@
// Top level of the table linear interpolator: stream ports, output skid, assertions.
// Depends on tli_pkg, tli_front and tli_divider.
`default_nettype none
// Usage: items arrive on the s_ channel. tdata packs, from bit 0: command,
// point_index, point_x, point_y, x_value. A write command stores one
// breakpoint and gives no result; an evaluate command gives one result
// on the m_ channel, tdata = {clamp_code, y_value} with y_value at bit 0.
// point_count is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while idle, and the block itself does not enforce this. Throughput is one item
// per cycle while s_axis_tready is high. An evaluation passes 3 front stages,
// one stage per quotient bit of the 66-bit restoring divider and the output
// register, 70 registers in all. The divider depth sets the latency. Reset clears
// all valid bits and sets point_count to 1; the table is not cleared and must be
// loaded before use. While a result waits with m_axis_tready low, the pipeline
// still moves to close a gap at its end; once a second result waits behind the
// output register, the whole pipeline holds and s_axis_tready drops.
module table_linear_interpolator_top #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = tli_pkg::FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[0], point_index[4:1], point_x[36:5], point_y[68:37], x_value[100:69]
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // y_value[31:0], clamp_code[33:32]
    output logic [39:0]       m_axis_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [4:0]   cfg_wr_data
);
    import tli_pkg::*;

    logic [4:0] count_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 5'd1;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // The output register loads when it is free or being drained; the pipeline
    // also moves when its last stage is empty.
    logic advance;
    logic out_load;
    logic out_v_reg;
    logic [33:0] out_d_reg;
    logic dv;
    logic [PROD_W-1:0] quot;
    ctx_t dctx;
    assign out_load = !out_v_reg || m_axis_tready;
    assign advance = out_load || !dv;
    assign s_axis_tready = advance;

    logic fv;
    logic [PROD_W-1:0] num;
    logic [DIV_W-1:0] den;
    ctx_t fctx;
    tli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk, .aresetn, .advance,
        .in_valid(s_axis_tvalid),
        .in_cmd(s_axis_tdata[0]),
        .in_index(s_axis_tdata[4:1]),
        .in_px(s_axis_tdata[36:5]),
        .in_py(s_axis_tdata[68:37]),
        .in_x(s_axis_tdata[100:69]),
        .count(count_reg),
        .out_valid(fv), .out_num(num), .out_den(den), .out_ctx(fctx)
    );

    tli_divider u_div (
        .aclk, .aresetn, .advance,
        .in_valid(fv), .in_num(num), .in_den(den), .in_ctx(fctx),
        .out_valid(dv), .out_quot(quot), .out_ctx(dctx)
    );

    // Sign, add base and saturate into the output register.
    logic signed [67:0] sum;
    logic signed [31:0] y_sat;
    always_comb begin
        if (dctx.zero_dx) begin
            sum = 68'(dctx.base_y);
        end else if (dctx.neg) begin
            sum = 68'(dctx.base_y) - $signed({2'b00, quot});
        end else begin
            sum = 68'(dctx.base_y) + $signed({2'b00, quot});
        end
        if (sum > 68'sd2147483647) begin
            y_sat = 32'sh7fffffff;
        end else if (sum < -68'sd2147483648) begin
            y_sat = 32'sh80000000;
        end else begin
            y_sat = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= dv;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_load && dv) begin
            out_d_reg <= {dctx.code, y_sat};
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'd0, out_d_reg};

    // A result never appears with a code that means nothing.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad clamp code");
    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // Input is refused only while a result waits both at the output and behind it.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> out_v_reg && dv && !m_axis_tready) else $error("spurious stall");
endmodule
`default_nettype wire
